@@ rtl/core/spectrum_band_peak_meter_top_assert.svh @@
// Assertion macros for the checker of the band peak meter.
`ifndef SPECTRUM_BAND_PEAK_METER_TOP_ASSERT_SVH
`define SPECTRUM_BAND_PEAK_METER_TOP_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define SBPM_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("sbpm assertion failed");

// The consequent must hold at the edge after the antecedent.
`define SBPM_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("sbpm assertion failed");

`endif

@@ rtl/core/sbpm_pkg.sv @@
package sbpm_pkg;

  localparam int BIN_COUNT_DEF = 512;
  localparam int MAG_WIDTH_DEF = 24;
  localparam int MAX_BANDS     = 512;

  localparam int BIN_W      = 9;
  localparam int MAG_W      = 24;
  localparam int SLOT_W     = 9;
  localparam int BVAL_W     = 10;
  localparam int COUNT_W    = 10;
  localparam int GAIN_W     = 16;
  localparam int SUM_W      = 33;
  localparam int BINS_W     = 10;
  localparam int PTR_W      = 9;
  localparam int PROD_W     = MAG_W + GAIN_W;
  localparam int GAIN_FRAC  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MAG_W-1:0] PEAK_MIN = MAG_W'(384);

  typedef enum logic [1:0] {
    REQ_BIN    = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_IGNORE = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    CMD_BIN   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_COUNT   = 3'd0,
    CFG_SCALE_GAIN   = 3'd1,
    CFG_FALLOFF      = 3'd2,
    CFG_HEIGHT_LIMIT = 3'd3,
    CFG_NOISE_FLOOR  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_ACC,
    ST_DIV,
    ST_MUL,
    ST_PEAK
  } back_state_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [BIN_W-1:0]    bin_index;
    logic [MAG_W-1:0]    addend;
    logic [SLOT_W-1:0]   slot;
    logic [BVAL_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [GAIN_W-1:0]  gain;
    logic [MAG_W-1:0]   falloff;
    logic [MAG_W-1:0]   limit;
    logic [MAG_W-1:0]   noise;
  } cfg_t;

endpackage

@@ rtl/core/sbpm_front.sv @@
module sbpm_front #(
  parameter int BIN_COUNT = sbpm_pkg::BIN_COUNT_DEF,
  parameter int MAG_WIDTH = sbpm_pkg::MAG_WIDTH_DEF
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [sbpm_pkg::BIN_W-1:0]  bin_index,
  input  logic [sbpm_pkg::MAG_W-1:0]  magnitude,
  input  logic [sbpm_pkg::SLOT_W-1:0] table_slot,
  input  logic [sbpm_pkg::BVAL_W-1:0] table_value,
  input  sbpm_pkg::cfg_t              cfg,
  input  sbpm_pkg::fifo_stat_t        qstat,
  input  logic                        back_ready,
  output logic                        push,
  output sbpm_pkg::cmd_t              cmd
);

  localparam int KEEP_W = (MAG_WIDTH < sbpm_pkg::MAG_W) ? MAG_WIDTH : sbpm_pkg::MAG_W;
  localparam logic [sbpm_pkg::MAG_W-1:0] KEEP_MASK =
    {sbpm_pkg::MAG_W{1'b1}} >> (sbpm_pkg::MAG_W - KEEP_W);

  logic [sbpm_pkg::MAG_W-1:0] mag;
  logic                       slot_ok;
  logic                       wanted;

  assign in_ready = back_ready && !qstat.full;
  assign mag      = magnitude & KEEP_MASK;
  assign slot_ok  = 32'(table_slot) < BIN_COUNT;

  always_comb begin
    cmd.bin_index = bin_index;
    cmd.addend    = (mag > cfg.noise) ? mag : '0;
    cmd.slot      = table_slot;
    cmd.value     = table_value;
    unique case (sbpm_pkg::req_code_t'(req_type))
      sbpm_pkg::REQ_BIN: begin
        cmd.kind = sbpm_pkg::CMD_BIN;
        wanted   = 1'b1;
      end
      sbpm_pkg::REQ_WRITE: begin
        cmd.kind = sbpm_pkg::CMD_WRITE;
        wanted   = slot_ok;
      end
      sbpm_pkg::REQ_CLEAR: begin
        cmd.kind = sbpm_pkg::CMD_CLEAR;
        wanted   = 1'b1;
      end
      default: begin
        cmd.kind = sbpm_pkg::CMD_BIN;
        wanted   = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && wanted;

endmodule

@@ rtl/core/sbpm_fifo.sv @@
module sbpm_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sbpm_pkg::cmd_t       wr_cmd,
  input  logic                 pop,
  output sbpm_pkg::cmd_t       head,
  output sbpm_pkg::fifo_stat_t stat
);

  localparam int AW = $clog2(sbpm_pkg::QUEUE_DEPTH);

  sbpm_pkg::cmd_t  slots [sbpm_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     fill;

  assign head       = slots[rd_ptr];
  assign stat.full  = fill == (AW + 1)'(sbpm_pkg::QUEUE_DEPTH);
  assign stat.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

@@ rtl/core/sbpm_div.sv @@
module sbpm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sbpm_pkg::SUM_W-1:0]  dividend,
  input  logic [sbpm_pkg::BINS_W-1:0] divisor,
  output logic                        done,
  output logic [sbpm_pkg::MAG_W-1:0]  quotient
);

  // The quotient is known to fit MAG_W bits, so the top bits of the dividend
  // start out as the partial remainder.
  localparam int QW    = sbpm_pkg::MAG_W;
  localparam int DW    = sbpm_pkg::BINS_W;
  localparam int CNT_W = $clog2(QW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    den;
  logic [QW-1:0]    work;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             q_bit;

  assign trial    = {rem, work[QW-1]};
  assign diff     = trial - {1'b0, den};
  assign q_bit    = trial >= {1'b0, den};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DW'(dividend[sbpm_pkg::SUM_W-1:QW]);
      work <= dividend[QW-1:0];
      den  <= divisor;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= q_bit ? diff[DW-1:0] : trial[DW-1:0];
      work <= {work[QW-2:0], q_bit};
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(QW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/sbpm_back.sv @@
module sbpm_back #(
  parameter int BIN_COUNT = sbpm_pkg::BIN_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sbpm_pkg::cfg_t              cfg,
  input  sbpm_pkg::cmd_t              head,
  input  sbpm_pkg::fifo_stat_t        qstat,
  output logic                        pop,
  output logic                        init_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sbpm_pkg::PTR_W-1:0]  band_number,
  output logic [sbpm_pkg::MAG_W-1:0]  bar_height,
  output logic                        last_band
);

  localparam int STORE_DEPTH =
    (BIN_COUNT < sbpm_pkg::MAX_BANDS) ? BIN_COUNT : sbpm_pkg::MAX_BANDS;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int PW  = sbpm_pkg::PTR_W;
  localparam int MW  = sbpm_pkg::MAG_W;
  localparam int CW  = sbpm_pkg::COUNT_W;
  localparam int SW  = sbpm_pkg::SUM_W;
  localparam int NW  = sbpm_pkg::BINS_W;
  localparam int VW  = sbpm_pkg::BVAL_W;
  localparam int XW  = sbpm_pkg::PROD_W;
  localparam int SCW = XW - sbpm_pkg::GAIN_FRAC;

  sbpm_pkg::back_state_t state;
  sbpm_pkg::back_state_t state_next;

  logic [VW-1:0] bnd_mem  [STORE_DEPTH];
  logic [MW-1:0] peak_mem [STORE_DEPTH];
  logic [VW-1:0] bnd_rd;
  logic [MW-1:0] peak_rd;

  sbpm_pkg::cmd_t cmd;
  logic [PW-1:0]  band_pointer;
  logic [SW-1:0]  band_sum;
  logic [NW-1:0]  bins_in_band;
  logic [VW-1:0]  lo;
  logic [MW-1:0]  quo;
  logic [XW-1:0]  prod;
  logic [AW-1:0]  sweep_idx;

  logic           bnd_re;
  logic           bnd_we;
  logic [AW-1:0]  bnd_raddr;
  logic           peak_re;
  logic           peak_we;
  logic [AW-1:0]  peak_addr;
  logic           div_start;
  logic           div_done;
  logic [MW-1:0]  div_q;
  logic           load_out;

  logic [PW-1:0]  cur_ptr;
  logic [PW-1:0]  lo_ptr;
  logic           ptr_ok;
  logic           in_band;
  logic [SW-1:0]  sum_new;
  logic [NW-1:0]  bins_new;
  logic           closes;
  logic           last_sweep;
  logic           out_free;
  logic [SCW-1:0] scaled;
  logic [MW-1:0]  clamped;
  logic [MW-1:0]  peak_next;

  assign cur_ptr    = (cmd.bin_index == '0) ? PW'(1) : band_pointer;
  assign lo_ptr     = cur_ptr - 1'b1;
  assign ptr_ok     = (cur_ptr != '0) && (CW'(cur_ptr) < cfg.count);
  assign in_band    = (VW'(cmd.bin_index) >= lo) && (VW'(cmd.bin_index) < bnd_rd);
  assign sum_new    = band_sum + (in_band ? SW'(cmd.addend) : '0);
  assign bins_new   = bins_in_band + NW'(in_band);
  assign closes     = (VW'(cmd.bin_index) + 1'b1) >= bnd_rd;
  assign last_sweep = sweep_idx == AW'(STORE_DEPTH - 1);
  assign out_free   = !out_valid || out_ready;

  assign scaled  = prod[XW-1:sbpm_pkg::GAIN_FRAC];
  assign clamped = (scaled > SCW'(cfg.limit)) ? cfg.limit : scaled[MW-1:0];

  always_comb begin
    if (peak_rd < clamped && clamped > sbpm_pkg::PEAK_MIN) begin
      peak_next = clamped;
    end else if (peak_rd > cfg.falloff) begin
      peak_next = peak_rd - cfg.falloff;
    end else begin
      peak_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sbpm_pkg::ST_SWEEP: begin
        if (last_sweep) begin
          state_next = sbpm_pkg::ST_IDLE;
        end
      end
      sbpm_pkg::ST_IDLE: begin
        if (!qstat.empty) begin
          unique case (head.kind)
            sbpm_pkg::CMD_BIN:   state_next = sbpm_pkg::ST_LO;
            sbpm_pkg::CMD_CLEAR: state_next = sbpm_pkg::ST_SWEEP;
            default:             state_next = sbpm_pkg::ST_IDLE;
          endcase
        end
      end
      sbpm_pkg::ST_LO: begin
        state_next = ptr_ok ? sbpm_pkg::ST_HI : sbpm_pkg::ST_IDLE;
      end
      sbpm_pkg::ST_HI: begin
        state_next = sbpm_pkg::ST_ACC;
      end
      sbpm_pkg::ST_ACC: begin
        if (!closes) begin
          state_next = sbpm_pkg::ST_IDLE;
        end else if (bins_new == '0) begin
          state_next = sbpm_pkg::ST_MUL;
        end else begin
          state_next = sbpm_pkg::ST_DIV;
        end
      end
      sbpm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = sbpm_pkg::ST_MUL;
        end
      end
      sbpm_pkg::ST_MUL: begin
        state_next = sbpm_pkg::ST_PEAK;
      end
      sbpm_pkg::ST_PEAK: begin
        if (out_free) begin
          state_next = sbpm_pkg::ST_IDLE;
        end
      end
      default: state_next = sbpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    bnd_re    = 1'b0;
    bnd_we    = 1'b0;
    bnd_raddr = band_pointer[AW-1:0];
    peak_re   = 1'b0;
    peak_we   = 1'b0;
    peak_addr = band_pointer[AW-1:0];
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      sbpm_pkg::ST_SWEEP: begin
        peak_we   = 1'b1;
        peak_addr = sweep_idx;
      end
      sbpm_pkg::ST_IDLE: begin
        pop    = !qstat.empty;
        bnd_we = !qstat.empty && head.kind == sbpm_pkg::CMD_WRITE;
      end
      sbpm_pkg::ST_LO: begin
        bnd_re    = ptr_ok;
        bnd_raddr = lo_ptr[AW-1:0];
      end
      sbpm_pkg::ST_HI: begin
        bnd_re = 1'b1;
      end
      sbpm_pkg::ST_ACC: begin
        peak_re   = closes;
        div_start = closes && bins_new != '0;
      end
      sbpm_pkg::ST_PEAK: begin
        peak_we  = out_free;
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem[head.slot[AW-1:0]] <= head.value;
    end
    if (bnd_re) begin
      bnd_rd <= bnd_mem[bnd_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (peak_we) begin
      peak_mem[peak_addr] <= (state == sbpm_pkg::ST_SWEEP) ? '0 : peak_next;
    end
    if (peak_re) begin
      peak_rd <= peak_mem[peak_addr];
    end
  end

  sbpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (bins_new),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (state == sbpm_pkg::ST_HI) begin
      lo <= bnd_rd;
    end
    if (state == sbpm_pkg::ST_ACC) begin
      quo <= '0;
    end else if (state == sbpm_pkg::ST_DIV && div_done) begin
      quo <= div_q;
    end
    if (state == sbpm_pkg::ST_MUL) begin
      prod <= XW'(quo) * XW'(cfg.gain);
    end
    if (load_out) begin
      band_number <= band_pointer;
      bar_height  <= peak_next;
      last_band   <= CW'(band_pointer) == cfg.count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sbpm_pkg::ST_SWEEP;
      sweep_idx    <= '0;
      init_done    <= 1'b0;
      band_pointer <= PW'(1);
      band_sum     <= '0;
      bins_in_band <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sbpm_pkg::ST_SWEEP) begin
        sweep_idx <= last_sweep ? '0 : sweep_idx + 1'b1;
        if (last_sweep) begin
          init_done <= 1'b1;
        end
      end
      if (state == sbpm_pkg::ST_LO && cmd.bin_index == '0) begin
        band_pointer <= PW'(1);
        band_sum     <= '0;
        bins_in_band <= '0;
      end
      if (state == sbpm_pkg::ST_ACC) begin
        band_sum     <= closes ? '0 : sum_new;
        bins_in_band <= closes ? '0 : bins_new;
      end
      if (load_out) begin
        band_pointer <= band_pointer + 1'b1;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/spectrum_band_peak_meter_top.sv @@
// Band peak meter: bins enter in index order and are grouped into bands by the
// boundary table; each closed band yields one item with its held peak. After
// reset the peak store is swept to zero over its STORE_DEPTH entries (512 by
// default) with in_ready low; a clear item runs the same sweep, with in_ready
// then set by the queue alone. In the back end a bin passes the LO, HI and ACC
// states, a boundary write is taken in IDLE, and a bin that closes a band goes
// on through the one-bit-a-cycle divider that averages the band (skipped when
// empty), the gain multiply and the peak update in the single-port peak memory.
module spectrum_band_peak_meter_top #(
  parameter int BIN_COUNT = sbpm_pkg::BIN_COUNT_DEF,
  parameter int MAG_WIDTH = sbpm_pkg::MAG_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbpm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [sbpm_pkg::BIN_W-1:0]      bin_index,
  input  logic [sbpm_pkg::MAG_W-1:0]      magnitude,
  input  logic [sbpm_pkg::SLOT_W-1:0]     table_slot,
  input  logic [sbpm_pkg::BVAL_W-1:0]     table_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sbpm_pkg::PTR_W-1:0]      band_number,
  output logic [sbpm_pkg::MAG_W-1:0]      bar_height,
  output logic                            last_band
);

  localparam int STORE_DEPTH =
    (BIN_COUNT < sbpm_pkg::MAX_BANDS) ? BIN_COUNT : sbpm_pkg::MAX_BANDS;
  localparam int CW = sbpm_pkg::COUNT_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] COUNT_MIN = CW'(2);

  logic [CW-1:0]               band_count;
  logic [sbpm_pkg::GAIN_W-1:0] scale_gain;
  logic [sbpm_pkg::MAG_W-1:0]  falloff_step;
  logic [sbpm_pkg::MAG_W-1:0]  height_limit;
  logic [sbpm_pkg::MAG_W-1:0]  noise_floor;

  sbpm_pkg::cfg_t       cfg;
  sbpm_pkg::cmd_t       wr_cmd;
  sbpm_pkg::cmd_t       head;
  sbpm_pkg::fifo_stat_t qstat;
  logic                 push;
  logic                 pop;
  logic                 back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count   <= COUNT_MIN;
      scale_gain   <= sbpm_pkg::GAIN_W'(256);
      falloff_step <= sbpm_pkg::MAG_W'(256);
      height_limit <= '1;
      noise_floor  <= '0;
    end else if (cfg_we) begin
      unique case (sbpm_pkg::cfg_reg_t'(cfg_index))
        sbpm_pkg::CFG_BAND_COUNT:   band_count   <= cfg_data[CW-1:0];
        sbpm_pkg::CFG_SCALE_GAIN:   scale_gain   <= cfg_data[sbpm_pkg::GAIN_W-1:0];
        sbpm_pkg::CFG_FALLOFF:      falloff_step <= cfg_data[sbpm_pkg::MAG_W-1:0];
        sbpm_pkg::CFG_HEIGHT_LIMIT: height_limit <= cfg_data[sbpm_pkg::MAG_W-1:0];
        sbpm_pkg::CFG_NOISE_FLOOR:  noise_floor  <= cfg_data[sbpm_pkg::MAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (band_count < COUNT_MIN) begin
      cfg.count = COUNT_MIN;
    end else if (band_count > COUNT_MAX) begin
      cfg.count = COUNT_MAX;
    end else begin
      cfg.count = band_count;
    end
    cfg.gain    = scale_gain;
    cfg.falloff = falloff_step;
    cfg.limit   = height_limit;
    cfg.noise   = noise_floor;
  end

  sbpm_front #(
    .BIN_COUNT (BIN_COUNT),
    .MAG_WIDTH (MAG_WIDTH)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .bin_index   (bin_index),
    .magnitude   (magnitude),
    .table_slot  (table_slot),
    .table_value (table_value),
    .cfg         (cfg),
    .qstat       (qstat),
    .back_ready  (back_ready),
    .push        (push),
    .cmd         (wr_cmd)
  );

  sbpm_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .stat   (qstat)
  );

  sbpm_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .init_done   (back_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .band_number (band_number),
    .bar_height  (bar_height),
    .last_band   (last_band)
  );

endmodule

@@ rtl/core/sbpm_checker.sv @@
`include "spectrum_band_peak_meter_top_assert.svh"

module sbpm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sbpm_pkg::PTR_W-1:0] band_number,
  input logic [sbpm_pkg::MAG_W-1:0] bar_height,
  input logic                       last_band
);

  // A waiting result keeps its contents until it is taken.
  `SBPM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(band_number) && $stable(bar_height) && $stable(last_band))

  // Band zero is never reported.
  `SBPM_ASSERT_NOW(a_band_nonzero, clk, rst, out_valid, band_number != '0)

  // Reset drops any pending result.
  `SBPM_ASSERT_NEXT(a_reset_out, clk, 1'b0, rst, !out_valid)

  // The peak store sweep keeps the input closed right after reset.
  `SBPM_ASSERT_NOW(a_reset_in, clk, 1'b0, $past(rst), !in_ready)

endmodule

bind spectrum_band_peak_meter_top sbpm_checker u_sbpm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .band_number (band_number),
  .bar_height  (bar_height),
  .last_band   (last_band)
);

@@ bench/spectrum_band_peak_meter_top_test.sv @@
module spectrum_band_peak_meter_top_test;
  import sbpm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 600;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PLAN_LEN = 24;

  typedef struct packed {
    logic [PTR_W-1:0] band;
    logic [MAG_W-1:0] height;
    logic             last;
  } bar_t;

  typedef struct {
    req_code_t          req;
    logic [BIN_W-1:0]   bin;
    logic [MAG_W-1:0]   mag;
    logic [SLOT_W-1:0]  slot;
    logic [BVAL_W-1:0]  value;
    logic               typed;
    bar_t               bar;
  } row_t;

  localparam bar_t NO_BAR = '0;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            req_type = '0;
  logic [BIN_W-1:0]      bin_index = '0;
  logic [MAG_W-1:0]      magnitude = '0;
  logic [SLOT_W-1:0]     table_slot = '0;
  logic [BVAL_W-1:0]     table_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PTR_W-1:0]      band_number;
  logic [MAG_W-1:0]      bar_height;
  logic                  last_band;

  spectrum_band_peak_meter_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .bin_index  (bin_index),
    .magnitude  (magnitude),
    .table_slot (table_slot),
    .table_value(table_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .band_number(band_number),
    .bar_height (bar_height),
    .last_band  (last_band)
  );

  // Shadow copy of the meter state and its registers.
  logic [BVAL_W-1:0] bound_tab [MAX_BANDS];
  logic [MAG_W-1:0]  peak_tab [MAX_BANDS];
  logic [SUM_W-1:0]  acc_sum = '0;
  logic [BINS_W-1:0] acc_bins = '0;
  logic [PTR_W-1:0]  band_ptr = 9'd1;
  logic [COUNT_W-1:0] cur_count = 10'd2;
  logic [GAIN_W-1:0]  cur_gain = 16'd256;
  logic [MAG_W-1:0]   cur_falloff = 24'd256;
  logic [MAG_W-1:0]   cur_limit = 24'hFFFFFF;
  logic [MAG_W-1:0]   cur_noise = 24'd0;

  bar_t bars_due [$];
  bar_t want;
  int fails = 0;
  int rand_items = 0;
  int phase_no = 0;
  int rdy_stall = 0;
  int rdy_roll;
  int unsigned cycles = 0;
  logic calm = 1'b0;
  row_t plan [PLAN_LEN];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("** spectrum_band_peak_meter_top: FAILED **");
    $finish;
  end

  // Applies one item to the shadow state and returns 1 when a band closes.
  function automatic logic meter_step(input req_code_t req, input logic [BIN_W-1:0] bin,
                                      input logic [MAG_W-1:0] mag,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [BVAL_W-1:0] value, output bar_t res);
    int k;
    int cnt;
    logic [BVAL_W-1:0] lo;
    logic [BVAL_W-1:0] hi;
    logic [PTR_W-1:0] p;
    logic [63:0] v;
    logic [MAG_W-1:0] pk;
    res = NO_BAR;
    case (req)
      REQ_WRITE: begin
        bound_tab[slot] = value;
        return 1'b0;
      end
      REQ_CLEAR: begin
        for (k = 0; k < MAX_BANDS; k++) peak_tab[k] = '0;
        return 1'b0;
      end
      REQ_BIN: begin
        cnt = (cur_count < 2) ? 2 : ((cur_count > 512) ? 512 : int'(cur_count));
        if (bin == 0) begin
          band_ptr = 9'd1;
          acc_sum = '0;
          acc_bins = '0;
        end
        p = band_ptr;
        if (int'(p) >= cnt || p == 0) return 1'b0;
        lo = bound_tab[p - 1];
        hi = bound_tab[p];
        if (bin >= lo && bin < hi) begin
          acc_sum = acc_sum + ((mag > cur_noise) ? mag : '0);
          acc_bins = acc_bins + 1'b1;
        end
        if (int'(bin) + 1 < int'(hi)) return 1'b0;
        v = (acc_bins != 0) ? 64'(acc_sum) / 64'(acc_bins) : 64'd0;
        v = (v * 64'(cur_gain)) >> GAIN_FRAC;
        if (v > 64'(cur_limit)) v = 64'(cur_limit);
        pk = peak_tab[p];
        if (64'(pk) < v && v > 64'(PEAK_MIN)) pk = v[MAG_W-1:0];
        else pk = (pk > cur_falloff) ? pk - cur_falloff : '0;
        peak_tab[p] = pk;
        res.band = p;
        res.height = pk;
        res.last = (int'(p) == cnt - 1);
        band_ptr = p + 1'b1;
        acc_sum = '0;
        acc_bins = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MAG_W-1:0] pick_mag();
    int t;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'hFFFFFF;
      2, 3: return $urandom_range(0, 1023);
      4: begin
        t = int'(cur_noise) + int'($urandom_range(0, 2)) - 1;
        if (t < 0) t = 0;
        if (t > 24'hFFFFFF) t = 24'hFFFFFF;
        return t;
      end
      5: return $urandom_range(380, 390);
      default: return $urandom & 24'hFFFFFF;
    endcase
  endfunction

  task automatic push_item(input req_code_t req, input logic [BIN_W-1:0] bin,
                           input logic [MAG_W-1:0] mag, input logic [SLOT_W-1:0] slot,
                           input logic [BVAL_W-1:0] value, input logic typed,
                           input bar_t typed_bar);
    int gap;
    bar_t res;
    logic made;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    bin_index <= bin;
    magnitude <= mag;
    table_slot <= slot;
    table_value <= value;
    do @(posedge clk); while (!in_ready);
    made = meter_step(req, bin, mag, slot, value, res);
    if (typed) bars_due.push_back(typed_bar);
    else if (made) bars_due.push_back(res);
  endtask

  task automatic send_bin(input int bin, input logic [MAG_W-1:0] mag);
    push_item(REQ_BIN, bin, mag, $urandom_range(0, 511), $urandom_range(0, 1023), 1'b0, NO_BAR);
    rand_items++;
  endtask

  task automatic send_write(input int slot, input int value);
    push_item(REQ_WRITE, $urandom_range(0, 511), $urandom & 24'hFFFFFF, slot, value, 1'b0,
              NO_BAR);
    rand_items++;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 9))
      0, 1, 2: push_item(REQ_IGNORE, $urandom_range(0, 511), $urandom & 24'hFFFFFF,
                         $urandom_range(0, 511), $urandom_range(0, 1023), 1'b0, NO_BAR);
      3: begin
        push_item(REQ_CLEAR, $urandom_range(0, 511), $urandom & 24'hFFFFFF,
                  $urandom_range(0, 511), $urandom_range(0, 1023), 1'b0, NO_BAR);
        rand_items++;
      end
      4: send_write($urandom_range(0, 511), $urandom_range(0, 512));
      default: send_bin($urandom_range(0, 511), pick_mag());
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bars_due.size() != 0);
  endtask

  task automatic write_regs(input logic [COUNT_W-1:0] cnt, input logic [GAIN_W-1:0] g,
                            input logic [MAG_W-1:0] fo, input logic [MAG_W-1:0] hl,
                            input logic [MAG_W-1:0] nf);
    cfg_reg_t idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    int k;
    idx = '{CFG_BAND_COUNT, CFG_SCALE_GAIN, CFG_FALLOFF, CFG_HEIGHT_LIMIT, CFG_NOISE_FLOOR};
    val = '{CFG_DATA_W'(cnt), CFG_DATA_W'(g), fo, hl, nf};
    for (k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_count = cnt;
    cur_gain = g;
    cur_falloff = fo;
    cur_limit = hl;
    cur_noise = nf;
  endtask

  // One setting of the registers, a fresh boundary table and a few frames of bins.
  task automatic run_phase();
    logic [COUNT_W-1:0] cnt;
    logic [GAIN_W-1:0] g;
    logic [MAG_W-1:0] fo;
    logic [MAG_W-1:0] hl;
    logic [MAG_W-1:0] nf;
    int eff;
    int endb;
    int lastb;
    int nframes;
    int f;
    int i;
    int r;
    int s;
    int k;
    int b;
    drain();
    repeat (SETTLE) @(posedge clk);
    calm <= ($urandom_range(0, 3) == 0);
    case (phase_no)
      1: begin
        cnt = $urandom_range(0, 1) ? 10'd512 : 10'd1023;
        g = 16'd256;
        fo = 24'd256;
        hl = 24'hFFFFFF;
        nf = 24'd0;
      end
      2: begin
        cnt = '0;
        g = '0;
        fo = '0;
        hl = '0;
        nf = '0;
      end
      3: begin
        cnt = 10'd12;
        g = 16'hFFFF;
        fo = 24'hFFFFFF;
        hl = 24'hFFFFFF;
        nf = '0;
      end
      4: begin
        cnt = 10'd1;
        g = 16'd256;
        fo = 24'd16;
        hl = 24'hFFFFFF;
        nf = 24'hFFFFFF;
      end
      default: begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        case ($urandom_range(0, 9))
          0: g = '0;
          1: g = 16'hFFFF;
          2, 3: g = 16'd256;
          4: g = $urandom;
          default: g = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 9))
          0: fo = '0;
          1: fo = 24'hFFFFFF;
          2: fo = $urandom & 24'hFFFFFF;
          default: fo = $urandom_range(0, 4096);
        endcase
        case ($urandom_range(0, 9))
          0: hl = '0;
          1: hl = $urandom & 24'hFFFFFF;
          2: hl = $urandom_range(0, 65535);
          default: hl = 24'hFFFFFF;
        endcase
        case ($urandom_range(0, 9))
          0: nf = 24'hFFFFFF;
          1: nf = $urandom & 24'hFFFFFF;
          2, 3: nf = $urandom_range(0, 2048);
          default: nf = '0;
        endcase
      end
    endcase
    write_regs(cnt, g, fo, hl, nf);
    eff = (cnt < 2) ? 2 : ((cnt > 512) ? 512 : int'(cnt));
    if (eff == 512) begin
      s = $urandom_range(1, 511);
      for (k = 0; k < 512; k++) send_write(k, k + ((k >= s) ? 1 : 0));
      endb = 512;
    end else begin
      b = $urandom_range(0, 3);
      for (k = 0; k < eff; k++) begin
        if (k > 0) begin
          r = $urandom_range(0, 19);
          b += (r == 0) ? 0 : ((r < 17) ? $urandom_range(1, 4) : $urandom_range(8, 40));
          if (b > 512) b = 512;
        end
        send_write(k, b);
      end
      endb = b;
    end
    lastb = ((endb > eff) ? endb : eff) - 1;
    if (lastb > 511) lastb = 511;
    nframes = (eff == 512) ? 1 : $urandom_range(2, 6);
    for (f = 0; f < nframes; f++) begin
      for (i = 0; i <= lastb; i++) begin
        r = $urandom_range(0, 299);
        if (r < 4) break;
        if (r < 10) send_noise();
        else if (r < 14) drain();
        else if (r < 30 && i != 0) continue;
        send_bin(i, pick_mag());
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_bin($urandom_range((lastb < 511) ? lastb + 1 : 511, 511), pick_mag());
        end
      end
    end
    phase_no++;
  endtask

  always @(posedge clk) begin
    if (rdy_stall > 0) begin
      out_ready <= 1'b0;
      rdy_stall--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      rdy_roll = $urandom_range(0, 99);
      if (rdy_roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rdy_stall = (rdy_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bars_due.size() == 0) begin
        $error("unexpected item: band_number %0d, bar_height %0h", band_number, bar_height);
        fails++;
      end else begin
        want = bars_due.pop_front();
        if (band_number !== want.band) begin
          $error("band_number: expected %0d, actual %0d", want.band, band_number);
          fails++;
        end
        if (bar_height !== want.height) begin
          $error("bar_height: expected %0h, actual %0h", want.height, bar_height);
          fails++;
        end
        if (last_band !== want.last) begin
          $error("last_band: expected %0b, actual %0b", want.last, last_band);
          fails++;
        end
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < MAX_BANDS; k++) peak_tab[k] = '0;
    // The typed rows run under the reset settings: count 2, unity gain, falloff 256.
    plan = '{
      '{REQ_WRITE,  9'd0,   24'h000000, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_WRITE,  9'd0,   24'h000000, 9'd1,   10'd4,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd0,   24'hFFFFFF, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd1,   24'hFFFFFF, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd2,   24'hFFFFFF, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd3,   24'hFFFFFF, 9'd0,   10'd0,    1'b1,
        bar_t'{9'd1, 24'hFFFFFF, 1'b1}},
      '{REQ_BIN,    9'd4,   24'h000005, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd0,   24'h000000, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd3,   24'h000000, 9'd0,   10'd0,    1'b1,
        bar_t'{9'd1, 24'hFFFEFF, 1'b1}},
      '{REQ_CLEAR,  9'd0,   24'h000000, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_IGNORE, 9'd511, 24'hFFFFFF, 9'd511, 10'd1023, 1'b0, NO_BAR},
      '{REQ_BIN,    9'd0,   24'd384,    9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd3,   24'd384,    9'd0,   10'd0,    1'b1,
        bar_t'{9'd1, 24'h000000, 1'b1}},
      '{REQ_BIN,    9'd0,   24'd385,    9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd3,   24'd385,    9'd0,   10'd0,    1'b1,
        bar_t'{9'd1, 24'h000181, 1'b1}},
      '{REQ_WRITE,  9'd0,   24'h000000, 9'd0,   10'd2,    1'b0, NO_BAR},
      '{REQ_WRITE,  9'd0,   24'h000000, 9'd1,   10'd4,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd0,   24'hFFFFFF, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd5,   24'h000007, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_WRITE,  9'd0,   24'h000000, 9'd0,   10'd510,  1'b0, NO_BAR},
      '{REQ_WRITE,  9'd0,   24'h000000, 9'd1,   10'd512,  1'b0, NO_BAR},
      '{REQ_BIN,    9'd0,   24'h00007B, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd510, 24'hFFFFFF, 9'd0,   10'd0,    1'b0, NO_BAR},
      '{REQ_BIN,    9'd511, 24'h000001, 9'd0,   10'd0,    1'b0, NO_BAR}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < PLAN_LEN; k++) begin
      push_item(plan[k].req, plan[k].bin, plan[k].mag, plan[k].slot, plan[k].value,
                plan[k].typed, plan[k].bar);
    end
    while (rand_items < RANDOM_ITEMS) run_phase();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && bars_due.size() == 0) begin
      $display("** spectrum_band_peak_meter_top: PASSED **");
    end else begin
      $display("** spectrum_band_peak_meter_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sbpm_pkg.sv
rtl/core/sbpm_front.sv
rtl/core/sbpm_fifo.sv
rtl/core/sbpm_div.sv
rtl/core/sbpm_back.sv
rtl/core/spectrum_band_peak_meter_top.sv
rtl/core/sbpm_checker.sv
bench/spectrum_band_peak_meter_top_test.sv
